// ----- rtl/srmd_pkg.sv -----
// Shared types, constants and helpers for the sorted rows merge distinct block.
package srmd_pkg;

  localparam int MAX_SIZE    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int WORD_BITS   = 32;
  localparam int CFG_BITS    = 5;
  localparam int EFF_BITS    = (VALUE_BITS < WORD_BITS) ? VALUE_BITS : WORD_BITS;
  localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);
  localparam int SUM_BITS    = CNT_BITS + 2;
  localparam int SIZE_BITS   = $clog2(MAX_SIZE + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_BITS-1:0]          count_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_LOADED = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic {
    PH_LOADING = 1'b0,
    PH_READY   = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MREAD = 2'd1,
    S_MCMP  = 2'd2,
    S_FETCH = 2'd3
  } state_t;

  typedef struct packed {
    opcode_t               opcode;
    logic signed [31:0]    element_value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0]    result_value;
    logic                  is_last;
    status_t               status;
  } res_word_t;

  function automatic count_t target_of(logic [CFG_BITS-1:0] m);
    logic [SIZE_BITS-1:0] n;
    if (m == '0) begin
      n = SIZE_BITS'(1);
    end else if (int'(m) > MAX_SIZE) begin
      n = SIZE_BITS'(MAX_SIZE);
    end else begin
      n = SIZE_BITS'(m);
    end
    return CNT_BITS'(count_t'(n) * count_t'(n));
  endfunction

  function automatic value_t to_store(logic [WORD_BITS-1:0] x);
    logic signed [EFF_BITS-1:0] t;
    t = x[EFF_BITS-1:0];
    return VALUE_BITS'(t);
  endfunction

  function automatic count_t min_cnt(logic [SUM_BITS-1:0] a, count_t c);
    return (a < SUM_BITS'(c)) ? CNT_BITS'(a) : c;
  endfunction

endpackage

// ----- rtl/sorted_rows_merge_distinct.sv -----
// Sorted rows merge distinct: loads an n-by-n matrix, then returns its distinct values in order.
// The load that completes n*n elements (n > 1) starts a bottom-up merge sort between two
// memory banks: ceil(log2(n*n)) passes, each element taking a read state and then a compare
// and write state, with duplicates dropped in the last pass; busy stays high meanwhile. A
// fetch goes through a memory read and then the result word. Status replies appear in the
// cycle after the command. Results are strobed by result_valid for one cycle and cannot be
// held off by the receiver. A configuration write restarts loading; it waits while start is
// high or busy is set.
module sorted_rows_merge_distinct (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  srmd_pkg::cmd_word_t               command,
  output logic                              result_valid,
  output srmd_pkg::res_word_t               result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srmd_pkg::CFG_BITS-1:0]     cfg_data
);

  srmd_pkg::value_t mem0 [srmd_pkg::STORE_DEPTH];
  srmd_pkg::value_t mem1 [srmd_pkg::STORE_DEPTH];

  srmd_pkg::state_t state, state_next;
  srmd_pkg::phase_t phase, phase_next;
  srmd_pkg::count_t target, target_next;
  srmd_pkg::count_t loaded, loaded_next;
  srmd_pkg::count_t distinct, distinct_next;
  srmd_pkg::count_t rp, rp_next;
  srmd_pkg::count_t w, w_next;
  srmd_pkg::count_t i, i_next;
  srmd_pkg::count_t j, j_next;
  srmd_pkg::count_t mid, mid_next;
  srmd_pkg::count_t hi, hi_next;
  srmd_pkg::count_t k, k_next;
  srmd_pkg::count_t d, d_next;
  srmd_pkg::value_t last_val, last_val_next;
  logic             src, src_next;
  logic             res_bank, res_bank_next;
  logic             result_valid_next;
  srmd_pkg::res_word_t result_next;

  srmd_pkg::addr_t  ra, rb, waddr;
  srmd_pkg::value_t wdata;
  logic             we, wbank;
  srmd_pkg::value_t da0, db0, da1, db1, da, db, val;

  logic accept, cfg_wr, is_load, load_ok, load_done;
  logic take_left, is_final, dup, pair_end, pass_end;
  logic [srmd_pkg::SUM_BITS-1:0] w2;

  assign busy      = (state != srmd_pkg::S_IDLE);
  assign cfg_ready = (state == srmd_pkg::S_IDLE) && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;
  assign is_load   = (command.opcode == srmd_pkg::OP_LOAD);
  assign load_ok   = (phase == srmd_pkg::PH_LOADING) && (loaded < target);
  assign load_done = accept && is_load && load_ok && (loaded + 1'b1 >= target);

  assign da  = src ? da1 : da0;
  assign db  = src ? db1 : db0;
  assign w2  = {srmd_pkg::SUM_BITS'(w)} << 1;
  assign is_final  = (w2 >= srmd_pkg::SUM_BITS'(target));
  assign take_left = (i < mid) && ((j >= hi) || (da <= db));
  assign val       = take_left ? da : db;
  assign dup       = is_final && (d != '0) && (val == last_val);
  assign pair_end  = (k + 1'b1 == hi);
  assign pass_end  = pair_end && (hi == target);

  always_comb begin
    if (state == srmd_pkg::S_IDLE) begin
      ra = rp[srmd_pkg::ADDR_BITS-1:0];
    end else begin
      ra = i[srmd_pkg::ADDR_BITS-1:0];
    end
    rb = j[srmd_pkg::ADDR_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srmd_pkg::S_IDLE: begin
        if (load_done && target > srmd_pkg::count_t'(1)) begin
          state_next = srmd_pkg::S_MREAD;
        end else if (accept && !is_load && phase == srmd_pkg::PH_READY && rp < distinct) begin
          state_next = srmd_pkg::S_FETCH;
        end
      end
      srmd_pkg::S_MREAD: state_next = srmd_pkg::S_MCMP;
      srmd_pkg::S_MCMP: begin
        state_next = (pass_end && is_final) ? srmd_pkg::S_IDLE : srmd_pkg::S_MREAD;
      end
      srmd_pkg::S_FETCH: state_next = srmd_pkg::S_IDLE;
      default: state_next = srmd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    target_next       = target;
    loaded_next       = loaded;
    distinct_next     = distinct;
    rp_next           = rp;
    w_next            = w;
    i_next            = i;
    j_next            = j;
    mid_next          = mid;
    hi_next           = hi;
    k_next            = k;
    d_next            = d;
    last_val_next     = last_val;
    src_next          = src;
    res_bank_next     = res_bank;
    result_valid_next = 1'b0;
    result_next       = result;
    we                = 1'b0;
    wbank             = 1'b0;
    waddr             = loaded[srmd_pkg::ADDR_BITS-1:0];
    wdata             = srmd_pkg::to_store(command.element_value);
    unique case (state)
      srmd_pkg::S_IDLE: begin
        if (cfg_wr) begin
          target_next   = srmd_pkg::target_of(cfg_data);
          loaded_next   = '0;
          distinct_next = '0;
          rp_next       = '0;
          phase_next    = srmd_pkg::PH_LOADING;
        end else if (accept && is_load) begin
          if (load_ok) begin
            we          = 1'b1;
            loaded_next = loaded + 1'b1;
            if (load_done) begin
              rp_next = '0;
              if (target == srmd_pkg::count_t'(1)) begin
                phase_next    = srmd_pkg::PH_READY;
                distinct_next = srmd_pkg::count_t'(1);
                res_bank_next = 1'b0;
              end else begin
                w_next   = srmd_pkg::count_t'(1);
                src_next = 1'b0;
                i_next   = '0;
                mid_next = srmd_pkg::count_t'(1);
                j_next   = srmd_pkg::count_t'(1);
                hi_next  = srmd_pkg::min_cnt(srmd_pkg::SUM_BITS'(2), target);
                k_next   = '0;
                d_next   = '0;
              end
            end
          end else begin
            result_valid_next = 1'b1;
            result_next       = '{result_value: '0, is_last: 1'b0,
                                  status: srmd_pkg::ST_OVERFLOW};
          end
        end else if (accept) begin
          if (phase != srmd_pkg::PH_READY) begin
            result_valid_next = 1'b1;
            result_next       = '{result_value: '0, is_last: 1'b0,
                                  status: srmd_pkg::ST_NOT_LOADED};
          end else if (rp >= distinct) begin
            result_valid_next = 1'b1;
            result_next       = '{result_value: '0, is_last: 1'b0,
                                  status: srmd_pkg::ST_EMPTY};
          end
        end
      end
      srmd_pkg::S_MREAD: begin
      end
      srmd_pkg::S_MCMP: begin
        we    = !dup;
        wbank = !src;
        waddr = is_final ? d[srmd_pkg::ADDR_BITS-1:0] : k[srmd_pkg::ADDR_BITS-1:0];
        wdata = val;
        if (take_left) begin
          i_next = i + 1'b1;
        end else begin
          j_next = j + 1'b1;
        end
        k_next = k + 1'b1;
        if (!dup) begin
          d_next        = d + 1'b1;
          last_val_next = val;
        end
        if (pass_end) begin
          if (is_final) begin
            phase_next    = srmd_pkg::PH_READY;
            distinct_next = dup ? d : d + 1'b1;
            res_bank_next = !src;
            rp_next       = '0;
          end else begin
            w_next   = srmd_pkg::count_t'(w2);
            src_next = !src;
            i_next   = '0;
            mid_next = srmd_pkg::min_cnt(w2, target);
            j_next   = srmd_pkg::min_cnt(w2, target);
            hi_next  = srmd_pkg::min_cnt(w2 << 1, target);
            k_next   = '0;
            d_next   = '0;
          end
        end else if (pair_end) begin
          i_next   = hi;
          mid_next = srmd_pkg::min_cnt(srmd_pkg::SUM_BITS'(hi) + srmd_pkg::SUM_BITS'(w), target);
          j_next   = srmd_pkg::min_cnt(srmd_pkg::SUM_BITS'(hi) + srmd_pkg::SUM_BITS'(w), target);
          hi_next  = srmd_pkg::min_cnt(srmd_pkg::SUM_BITS'(hi) + w2, target);
        end
      end
      srmd_pkg::S_FETCH: begin
        result_valid_next = 1'b1;
        result_next       = '{result_value: 32'(res_bank ? da1 : da0),
                              is_last: (rp + 1'b1 == distinct),
                              status: srmd_pkg::ST_OK};
        rp_next           = rp + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // banks: loads go to bank 0; a merge pass reads one bank and writes the other
  always_ff @(posedge clk) begin
    if (we && !wbank) begin
      mem0[waddr] <= wdata;
    end
    if (we && wbank) begin
      mem1[waddr] <= wdata;
    end
    da0 <= mem0[ra];
    db0 <= mem0[rb];
    da1 <= mem1[ra];
    db1 <= mem1[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= srmd_pkg::S_IDLE;
      phase        <= srmd_pkg::PH_LOADING;
      target       <= srmd_pkg::target_of(srmd_pkg::CFG_BITS'(16));
      loaded       <= '0;
      distinct     <= '0;
      rp           <= '0;
      src          <= 1'b0;
      res_bank     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      target       <= target_next;
      loaded       <= loaded_next;
      distinct     <= distinct_next;
      rp           <= rp_next;
      src          <= src_next;
      res_bank     <= res_bank_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    w        <= w_next;
    i        <= i_next;
    j        <= j_next;
    mid      <= mid_next;
    hi       <= hi_next;
    k        <= k_next;
    d        <= d_next;
    last_val <= last_val_next;
    result   <= result_next;
  end

  a_rp_bound: assert property (@(posedge clk) disable iff (rst)
    rp <= distinct)
    else $error("read position past distinct count");

  a_ok_needs_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == srmd_pkg::ST_OK |-> phase == srmd_pkg::PH_READY)
    else $error("ok word before sort finished");

  a_sort_while_loading: assert property (@(posedge clk) disable iff (rst)
    (state == srmd_pkg::S_MREAD || state == srmd_pkg::S_MCMP)
      |-> phase == srmd_pkg::PH_LOADING)
    else $error("merge running in ready phase");

  a_status_word_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != srmd_pkg::ST_OK
      |-> result.result_value == '0 && !result.is_last)
    else $error("status word carries data");

endmodule

// ----- tb/sorted_rows_merge_distinct_tb.sv -----
// Testbench for sorted_rows_merge_distinct: directed table, then random load/fetch phases.
`timescale 1ns / 1ps

module sorted_rows_merge_distinct_tb;

  typedef struct packed {
    logic                is_cfg;
    logic [4:0]          size;
    srmd_pkg::cmd_word_t word;
    logic                typed;
    srmd_pkg::res_word_t reply;
  } step_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  srmd_pkg::cmd_word_t command = '0;
  logic      result_valid;
  srmd_pkg::res_word_t result;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [srmd_pkg::CFG_BITS-1:0] cfg_data = '0;

  // typed expectation travels with the command word
  logic      typed_on = 1'b0;
  srmd_pkg::res_word_t typed_reply = '0;

  // shadow of the block
  srmd_pkg::value_t stored [srmd_pkg::STORE_DEPTH];
  logic [4:0] size_reg;
  int        n_loaded;
  int        n_distinct;
  int        rd_pos;
  srmd_pkg::phase_t cur_phase;

  srmd_pkg::res_word_t pending_replies[$];
  step_t     plan[$];
  int        errors = 0;
  int        issued = 0;
  bit        burst = 1'b0;

  sorted_rows_merge_distinct dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int eff_size(input logic [4:0] m);
    if (m == 5'd0) return 1;
    if (int'(m) > srmd_pkg::MAX_SIZE) return srmd_pkg::MAX_SIZE;
    return int'(m);
  endfunction

  function automatic bit predict_reply(input srmd_pkg::cmd_word_t c,
                                       output srmd_pkg::res_word_t r);
    int tgt;
    int i;
    int j;
    int k;
    srmd_pkg::value_t key;
    r = '0;
    r.status = srmd_pkg::ST_OK;
    tgt = eff_size(size_reg) * eff_size(size_reg);
    if (c.opcode == srmd_pkg::OP_LOAD) begin
      if (cur_phase != srmd_pkg::PH_LOADING || n_loaded >= tgt) begin
        r.status = srmd_pkg::ST_OVERFLOW;
        return 1'b1;
      end
      stored[n_loaded] = c.element_value;
      n_loaded++;
      if (n_loaded >= tgt) begin
        for (i = 1; i < n_loaded; i++) begin
          key = stored[i];
          j = i;
          while (j > 0 && stored[j-1] > key) begin
            stored[j] = stored[j-1];
            j--;
          end
          stored[j] = key;
        end
        k = 0;
        for (i = 0; i < n_loaded; i++) begin
          if (k == 0 || stored[k-1] != stored[i]) begin
            stored[k] = stored[i];
            k++;
          end
        end
        n_distinct = k;
        rd_pos = 0;
        cur_phase = srmd_pkg::PH_READY;
      end
      return 1'b0;
    end
    if (cur_phase != srmd_pkg::PH_READY) begin
      r.status = srmd_pkg::ST_NOT_LOADED;
      return 1'b1;
    end
    if (rd_pos >= n_distinct) begin
      r.status = srmd_pkg::ST_EMPTY;
      return 1'b1;
    end
    r.result_value = stored[rd_pos];
    r.is_last = (rd_pos + 1 == n_distinct);
    rd_pos++;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    srmd_pkg::res_word_t want;
    srmd_pkg::res_word_t pr;
    bit has;
    if (rst) begin
      size_reg = 5'd16;
      n_loaded = 0;
      n_distinct = 0;
      rd_pos = 0;
      cur_phase = srmd_pkg::PH_LOADING;
      pending_replies.delete();
    end else begin
      if (result_valid) begin
        if (pending_replies.size() == 0) begin
          flag("unexpected word", result.result_value, '0);
        end else begin
          want = pending_replies.pop_front();
          if (result.result_value !== want.result_value)
            flag("result_value", result.result_value, want.result_value);
          if (result.is_last !== want.is_last)
            flag("is_last", 32'(result.is_last), 32'(want.is_last));
          if (result.status !== want.status)
            flag("status", 32'(result.status), 32'(want.status));
        end
      end
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
        n_loaded = 0;
        n_distinct = 0;
        rd_pos = 0;
        cur_phase = srmd_pkg::PH_LOADING;
      end
      if (start && !busy) begin
        has = predict_reply(command, pr);
        if (typed_on) pending_replies.push_back(typed_reply);
        else if (has) pending_replies.push_back(pr);
      end
    end
  end

  // leaves start high when no gap follows; caller lowers it before any wait
  task automatic issue(input srmd_pkg::cmd_word_t w, input logic typed,
                       input srmd_pkg::res_word_t reply);
    int r;
    int gap;
    start <= 1'b1;
    command <= w;
    typed_on <= typed;
    typed_reply <= reply;
    do @(posedge clk); while (busy);
    issued++;
    r = $urandom_range(0, 9);
    if (burst || r < 4) gap = 0;
    else if (r < 8) gap = $urandom_range(1, 3);
    else if (r == 8) gap = $urandom_range(4, 10);
    else gap = $urandom_range(11, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_size(input logic [4:0] v);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add(input logic is_cfg, input logic [4:0] size, input srmd_pkg::opcode_t op,
                     input logic [31:0] v, input logic typed, input srmd_pkg::status_t st,
                     input logic [31:0] rv, input logic last);
    step_t s;
    s.is_cfg = is_cfg;
    s.size = size;
    s.word.opcode = op;
    s.word.element_value = v;
    s.typed = typed;
    s.reply.result_value = rv;
    s.reply.is_last = last;
    s.reply.status = st;
    plan.push_back(s);
  endtask

  initial begin
    srmd_pkg::cmd_word_t w;
    srmd_pkg::res_word_t none;
    logic [4:0] sz;
    logic [31:0] v;
    logic [31:0] pool [4];
    int n;
    int mode;
    int i;
    int k;
    int fetches;

    none = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_NOT_LOADED, 32'h0, 1'b0);
    add(1'b1, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'hffffffff, 1'b1, srmd_pkg::ST_NOT_LOADED,
        32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'h80000000, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_OK, 32'h80000000, 1'b1);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_EMPTY, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'h7fffffff, 1'b1, srmd_pkg::ST_OVERFLOW, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_EMPTY, 32'h0, 1'b0);
    add(1'b1, 5'd2, srmd_pkg::OP_FETCH, 32'h0, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'hffffffff, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'h7fffffff, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_NOT_LOADED, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'h80000000, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'hffffffff, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_OK, 32'h80000000, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_OK, 32'hffffffff, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_OK, 32'h7fffffff, 1'b1);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_EMPTY, 32'h0, 1'b0);
    add(1'b1, 5'd31, srmd_pkg::OP_FETCH, 32'h0, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_NOT_LOADED, 32'h0, 1'b0);
    add(1'b1, 5'd2, srmd_pkg::OP_FETCH, 32'h0, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'h55555555, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'haaaaaaaa, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'h55555555, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_LOAD, 32'haaaaaaaa, 1'b0, srmd_pkg::ST_OK, 32'h0, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_OK, 32'haaaaaaaa, 1'b0);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_OK, 32'h55555555, 1'b1);
    add(1'b0, 5'd0, srmd_pkg::OP_FETCH, 32'h0, 1'b1, srmd_pkg::ST_EMPTY, 32'h0, 1'b0);

    foreach (plan[p]) begin
      if (plan[p].is_cfg) set_size(plan[p].size);
      else issue(plan[p].word, plan[p].typed, plan[p].reply);
    end

    while (issued < 450) begin
      k = $urandom_range(0, 19);
      if (k == 0) sz = 5'd0;
      else if (k == 1) sz = 5'($urandom_range(16, 31));
      else if (k < 5) sz = 5'($urandom_range(6, 15));
      else sz = 5'($urandom_range(1, 5));
      set_size(sz);
      n = eff_size(sz);
      mode = $urandom_range(0, 3);
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 4; i++) pool[i] = $urandom;
      v = $urandom;
      for (i = 0; i < n * n && issued < 450; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          w.opcode = srmd_pkg::OP_FETCH;
          w.element_value = $urandom;
          issue(w, 1'b0, none);
        end
        case (mode)
          0: v = $urandom;
          1: v = pool[$urandom_range(0, 3)];
          2: if (i % n == 0) v = $urandom; else v = v + $urandom_range(0, 2);
          default: begin
            case ($urandom_range(0, 4))
              0: v = 32'h80000000;
              1: v = 32'h7fffffff;
              2: v = 32'h0;
              3: v = 32'hffffffff;
              default: v = $urandom;
            endcase
          end
        endcase
        w.opcode = srmd_pkg::OP_LOAD;
        w.element_value = v;
        issue(w, 1'b0, none);
      end
      // let the shadow catch up on the completing load
      start <= 1'b0;
      @(posedge clk);
      fetches = n_distinct + $urandom_range(1, 3);
      for (i = 0; i < fetches && issued < 450; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          w.opcode = srmd_pkg::OP_LOAD;
          w.element_value = $urandom;
          issue(w, 1'b0, none);
        end
        w.opcode = srmd_pkg::OP_FETCH;
        w.element_value = $urandom;
        issue(w, 1'b0, none);
      end
    end

    start <= 1'b0;
    k = 0;
    while (pending_replies.size() != 0 && k < 50000) begin
      @(posedge clk);
      k++;
    end
    repeat (16) @(posedge clk);
    if (pending_replies.size() != 0) flag("missing words", 32'(pending_replies.size()), '0);
    if (errors == 0) begin
      $display("[sorted_rows_merge_distinct] OK");
    end else begin
      $display("[sorted_rows_merge_distinct] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[sorted_rows_merge_distinct] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/srmd_pkg.sv
rtl/sorted_rows_merge_distinct.sv
tb/sorted_rows_merge_distinct_tb.sv
